[design/dis_pkg.sv]
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types, codes and default constants for the dual-issue scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

package dis_pkg;

    localparam int NUM_REGS_DEF    = 64;
    localparam int MAX_LATENCY_DEF = 63;

    localparam int FIELD_REG_W = 6;
    localparam int FIELD_LAT_W = 6;

    localparam logic [2:0] ISSUE_WIDTH_RESET = 3'd2;
    localparam logic [2:0] ISSUE_WIDTH_MAX   = 3'd4;

    // Port claim bits.
    localparam int PORT_MEM = 0;
    localparam int PORT_FPU = 1;
    localparam int PORT_MD  = 2;

    // Divider units.
    localparam int UNIT_FDIV = 0;
    localparam int UNIT_IDIV = 1;

    typedef enum logic [1:0] {
        FUNC_QUERY = 2'd0,
        FUNC_ISSUE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_MEM    = 3'd1,
        CLS_FP     = 3'd2,
        CLS_FDIV   = 3'd3,
        CLS_IMUL   = 3'd4,
        CLS_IDIV   = 3'd5,
        CLS_RSVD6  = 3'd6,
        CLS_RSVD7  = 3'd7
    } op_class_t;

    typedef struct packed {
        func_t                  func;
        op_class_t              op_class;
        logic [FIELD_REG_W-1:0] src1_reg;
        logic                   src1_valid;
        logic [FIELD_REG_W-1:0] src2_reg;
        logic                   src2_valid;
        logic [FIELD_REG_W-1:0] src3_reg;
        logic                   src3_valid;
        logic [FIELD_REG_W-1:0] dest_reg;
        logic                   dest_valid;
        logic [FIELD_LAT_W-1:0] latency;
    } item_t;

endpackage : dis_pkg

`default_nettype wire

[design/dis_reg_timers.sv]
// ----------------------------------------------------------------------------
// dis_reg_timers
// One ready countdown per architectural register, all decremented together.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_reg_timers
    import dis_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int MAX_LATENCY = MAX_LATENCY_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            tick,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(NUM_REGS)-1:0]     wr_idx,
    input  wire logic [$clog2(MAX_LATENCY+1)-1:0] wr_val,
    output logic      [NUM_REGS-1:0]             busy
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int LAT_W = $clog2(MAX_LATENCY + 1);

    logic [LAT_W-1:0] cnt_reg [NUM_REGS];

    for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i] <= '0;
            end
            else if (wr_en && (wr_idx == IDX_W'(i)))
            begin
                cnt_reg[i] <= wr_val;
            end
            else if (tick && (cnt_reg[i] != '0))
            begin
                cnt_reg[i] <= cnt_reg[i] - 1'b1;
            end
        end

        assign busy[i] = (cnt_reg[i] != '0);
    end

endmodule : dis_reg_timers

`default_nettype wire

[design/dual_issue_scoreboard.sv]
// ----------------------------------------------------------------------------
// dual_issue_scoreboard
// In-order multi-issue scoreboard: issue checks, slot and port tracking.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the item channel is a query, an issue or a tick.
// Exactly one transaction comes out on the result channel for every item:
// can_issue answers a query (0 for anything else) and free_slots is the
// slot count left after the item.
// An accepted item sits in the input register, where it is checked against
// the scoreboard and the state is updated as it moves on; its result is
// then held in the result register until the receiver takes it. One item
// is taken per cycle while the receiver does not stall, set by the single
// pass through the check logic between those two registers.
// Every register countdown has its own decrementer, so a tick passes
// through like any other item.
// When the receiver stalls, the result register holds, the input register
// holds one more item behind it, and then item_ready falls.
// Reset clears all countdowns and port claims and sets the issue width and
// the slot count to 2. cfg_wdata is written on cfg_we (clamped to 4) and
// takes effect at the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_issue_scoreboard
    import dis_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int MAX_LATENCY = MAX_LATENCY_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata,

    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [1:0] func,
    input  wire logic [2:0] op_class,
    input  wire logic [5:0] src1_reg,
    input  wire logic       src1_valid,
    input  wire logic [5:0] src2_reg,
    input  wire logic       src2_valid,
    input  wire logic [5:0] src3_reg,
    input  wire logic       src3_valid,
    input  wire logic [5:0] dest_reg,
    input  wire logic       dest_valid,
    input  wire logic [5:0] latency,

    output logic            result_valid,
    input  wire logic       result_ready,
    output logic            can_issue,
    output logic [2:0]      free_slots
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int LAT_W = $clog2(MAX_LATENCY + 1);

    // Input register.
    logic  stage_valid_reg;
    item_t stage_reg;
    item_t item_in;

    // Scoreboard state.
    logic [2:0]       issue_width_reg;
    logic [2:0]       slots_left_reg;
    logic [2:0]       slots_left_next;
    logic [2:0]       port_claimed_reg;
    logic [2:0]       port_claimed_next;
    logic [LAT_W-1:0] unit_busy_reg [2];
    logic [LAT_W-1:0] unit_busy_next [2];

    // Result register.
    logic       result_valid_reg;
    logic       can_issue_reg;
    logic       can_issue_next;
    logic [2:0] free_slots_reg;

    logic [NUM_REGS-1:0] reg_busy;
    logic                advance;
    logic                is_query;
    logic                is_issue;
    logic                is_tick;
    logic                dest_wr;
    logic [LAT_W-1:0]    lat_sat;
    logic                src1_ok;
    logic                src2_ok;
    logic                src3_ok;
    logic                class_ok;

    function automatic logic src_ok(
        input logic                   used,
        input logic [FIELD_REG_W-1:0] idx,
        input logic [NUM_REGS-1:0]    busy_vec
    );
        logic in_range;
        in_range = ({3'b000, idx} < 9'(NUM_REGS));
        return !used || !in_range || !busy_vec[IDX_W'(idx)];
    endfunction

    assign item_in = '{
        func:       func_t'(func),
        op_class:   op_class_t'(op_class),
        src1_reg:   src1_reg,
        src1_valid: src1_valid,
        src2_reg:   src2_reg,
        src2_valid: src2_valid,
        src3_reg:   src3_reg,
        src3_valid: src3_valid,
        dest_reg:   dest_reg,
        dest_valid: dest_valid,
        latency:    latency
    };

    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    assign is_query = advance && (stage_reg.func == FUNC_QUERY);
    assign is_issue = advance && (stage_reg.func == FUNC_ISSUE);
    assign is_tick  = advance && (stage_reg.func == FUNC_TICK);

    always_comb
    begin
        if ({3'b000, stage_reg.latency} > 9'(MAX_LATENCY))
        begin
            lat_sat = LAT_W'(MAX_LATENCY);
        end
        else
        begin
            lat_sat = LAT_W'(stage_reg.latency);
        end
    end

    assign src1_ok = src_ok(stage_reg.src1_valid, stage_reg.src1_reg, reg_busy);
    assign src2_ok = src_ok(stage_reg.src2_valid, stage_reg.src2_reg, reg_busy);
    assign src3_ok = src_ok(stage_reg.src3_valid, stage_reg.src3_reg, reg_busy);

    // Port and divider checks; integer multiply checks the mul/div port only.
    always_comb
    begin
        case (stage_reg.op_class)
            CLS_MEM:  class_ok = !port_claimed_reg[PORT_MEM];
            CLS_FP:   class_ok = !port_claimed_reg[PORT_FPU];
            CLS_FDIV: class_ok = !port_claimed_reg[PORT_FPU] &&
                                 (unit_busy_reg[UNIT_FDIV] == '0);
            CLS_IMUL: class_ok = !port_claimed_reg[PORT_MD];
            CLS_IDIV: class_ok = !port_claimed_reg[PORT_MD] &&
                                 (unit_busy_reg[UNIT_IDIV] == '0);
            default:  class_ok = 1'b1;
        endcase
    end

    assign can_issue_next = is_query && (slots_left_reg != '0) && class_ok &&
                            src1_ok && src2_ok && src3_ok;

    always_comb
    begin
        slots_left_next   = slots_left_reg;
        port_claimed_next = port_claimed_reg;
        unit_busy_next    = unit_busy_reg;

        if (is_issue)
        begin
            if (slots_left_reg != '0)
            begin
                slots_left_next = slots_left_reg - 3'd1;
            end
            case (stage_reg.op_class)
                CLS_MEM:  port_claimed_next[PORT_MEM] = 1'b1;
                CLS_FP:   port_claimed_next[PORT_FPU] = 1'b1;
                CLS_FDIV:
                begin
                    port_claimed_next[PORT_FPU] = 1'b1;
                    unit_busy_next[UNIT_FDIV]   = lat_sat;
                end
                CLS_IDIV:
                begin
                    port_claimed_next[PORT_MD] = 1'b1;
                    unit_busy_next[UNIT_IDIV]  = lat_sat;
                end
                default: ;
            endcase
        end
        else if (is_tick)
        begin
            slots_left_next   = issue_width_reg;
            port_claimed_next = '0;
            for (int u = 0; u < 2; u++)
            begin
                if (unit_busy_reg[u] != '0)
                begin
                    unit_busy_next[u] = unit_busy_reg[u] - 1'b1;
                end
            end
        end
    end

    assign dest_wr = is_issue && stage_reg.dest_valid &&
                     ({3'b000, stage_reg.dest_reg} < 9'(NUM_REGS));

    dis_reg_timers #(
        .NUM_REGS    (NUM_REGS),
        .MAX_LATENCY (MAX_LATENCY)
    ) u_timers (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .wr_en  (dest_wr),
        .wr_idx (IDX_W'(stage_reg.dest_reg)),
        .wr_val (lat_sat),
        .busy   (reg_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_width_reg <= ISSUE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            issue_width_reg <= (cfg_wdata > ISSUE_WIDTH_MAX) ? ISSUE_WIDTH_MAX : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            slots_left_reg   <= ISSUE_WIDTH_RESET;
            port_claimed_reg <= '0;
            unit_busy_reg[0] <= '0;
            unit_busy_reg[1] <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            slots_left_reg   <= slots_left_next;
            port_claimed_reg <= port_claimed_next;
            unit_busy_reg    <= unit_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_reg <= item_in;
        end
        if (advance)
        begin
            can_issue_reg  <= can_issue_next;
            free_slots_reg <= slots_left_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign can_issue    = can_issue_reg;
    assign free_slots   = free_slots_reg;

    // A tick releases every port claim.
    a_tick_clears_ports: assert property (@(posedge clk) disable iff (!rst_n)
        is_tick |=> (port_claimed_reg == '0))
        else $error("port claims not released by tick");

    // An issue with a slot available consumes exactly one slot.
    a_issue_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (is_issue && (slots_left_reg != '0))
        |=> (slots_left_reg == ($past(slots_left_reg) - 3'd1)))
        else $error("issue did not take one slot");

    // The slot count never exceeds the widest issue.
    a_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        slots_left_reg <= ISSUE_WIDTH_MAX)
        else $error("slot count above maximum issue width");

    // Only a query can produce a positive issue answer.
    a_can_issue_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (stage_reg.func != FUNC_QUERY)) |=> !can_issue_reg)
        else $error("can_issue set for a non-query item");

endmodule : dual_issue_scoreboard

`default_nettype wire

[sim/issue_checker.sv]
// ----------------------------------------------------------------------------
// issue_checker
// Watches the item and result channels of the dual-issue scoreboard, keeps
// its own copy of the scoreboard state and checks every result in order.
// ----------------------------------------------------------------------------
module issue_checker
    import dis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       item_valid,
    input  logic       item_ready,
    input  item_t      item,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic       can_issue,
    input  logic [2:0] free_slots,
    output int         mismatches,
    output int         pending,
    output int         granted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       can_issue;
        logic [2:0] free_slots;
    } answer_t;

    logic [5:0] ready_cnt [NUM_REGS_DEF];
    logic [5:0] div_busy [2];
    logic [2:0] claimed;
    logic [2:0] slots;
    logic [2:0] width;

    answer_t answers_due [$];

    task automatic report_mismatch(input string msg);
        // Only the first few are printed; all of them are counted.
        if (mismatches < 20)
            $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic src_clear(input logic used, input logic [5:0] idx);
        return !used || (ready_cnt[idx] == '0);
    endfunction

    // Applies one transaction to the shadow scoreboard and returns its answer.
    task automatic apply_item(input item_t it, output answer_t ans);
        op_class_t cls;
        logic      ok;
        cls = it.op_class;
        if (cls == CLS_RSVD6 || cls == CLS_RSVD7)
            cls = CLS_OTHER;
        ans = '0;
        case (it.func)
            FUNC_QUERY:
            begin
                ok = (slots != '0);
                case (cls)
                    CLS_MEM:  ok &= !claimed[PORT_MEM];
                    CLS_FP:   ok &= !claimed[PORT_FPU];
                    CLS_FDIV: ok &= !claimed[PORT_FPU] && (div_busy[UNIT_FDIV] == '0);
                    CLS_IMUL: ok &= !claimed[PORT_MD];
                    CLS_IDIV: ok &= !claimed[PORT_MD] && (div_busy[UNIT_IDIV] == '0);
                    default:  ;
                endcase
                ok &= src_clear(it.src1_valid, it.src1_reg);
                ok &= src_clear(it.src2_valid, it.src2_reg);
                ok &= src_clear(it.src3_valid, it.src3_reg);
                ans.can_issue = ok;
                if (ok)
                    granted++;
            end
            FUNC_ISSUE:
            begin
                // An issue is applied even when its checks would fail.
                if (slots != '0)
                    slots--;
                case (cls)
                    CLS_MEM:  claimed[PORT_MEM] = 1'b1;
                    CLS_FP:   claimed[PORT_FPU] = 1'b1;
                    CLS_FDIV:
                    begin
                        claimed[PORT_FPU]   = 1'b1;
                        div_busy[UNIT_FDIV] = it.latency;
                    end
                    CLS_IDIV:
                    begin
                        claimed[PORT_MD]    = 1'b1;
                        div_busy[UNIT_IDIV] = it.latency;
                    end
                    default:  ;
                endcase
                if (it.dest_valid)
                    ready_cnt[it.dest_reg] = it.latency;
            end
            FUNC_TICK:
            begin
                slots = width;
                foreach (ready_cnt[r])
                    if (ready_cnt[r] != '0)
                        ready_cnt[r]--;
                foreach (div_busy[u])
                    if (div_busy[u] != '0)
                        div_busy[u]--;
                claimed = '0;
            end
            default: ;
        endcase
        ans.free_slots = slots;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            foreach (ready_cnt[r])
                ready_cnt[r] = '0;
            foreach (div_busy[u])
                div_busy[u] = '0;
            claimed = '0;
            width   = ISSUE_WIDTH_RESET;
            slots   = ISSUE_WIDTH_RESET;
            answers_due.delete();
            mismatches = 0;
            pending    = 0;
            granted    = 0;
        end
        else
        begin
            // The new width only takes effect at the next tick.
            if (cfg_we)
                width = (cfg_wdata > ISSUE_WIDTH_MAX) ? ISSUE_WIDTH_MAX : cfg_wdata;
            if (result_valid && result_ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("result (%0b, %0d) with no transaction pending",
                                              can_issue, free_slots));
                else
                begin
                    want = answers_due.pop_front();
                    if (can_issue !== want.can_issue)
                        report_mismatch($sformatf("can_issue got %0b expected %0b",
                                                  can_issue, want.can_issue));
                    if (free_slots !== want.free_slots)
                        report_mismatch($sformatf("free_slots got %0d expected %0d",
                                                  free_slots, want.free_slots));
                end
            end
            if (item_valid && item_ready)
            begin
                apply_item(item, want);
                answers_due.push_back(want);
            end
            pending = answers_due.size();
        end
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random query, issue, tick and unused-code transactions into the
// dual-issue scoreboard over several issue widths, with random idling on
// both channels and one long result stall; the checker judges the results.
// ----------------------------------------------------------------------------
module testbench;
    import dis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT          = 1_000_000;
    localparam int PHASE_ITEMS    = 140;
    localparam int BACKLOG_AT     = 520;
    localparam int BACKLOG_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;
    logic       item_valid;
    logic       item_ready;
    item_t      offer;
    logic       result_valid;
    logic       result_ready;
    logic       can_issue;
    logic [2:0] free_slots;

    int mismatches;
    int pending;
    int granted;
    int items_sent = 0;
    int n_query    = 0;
    int n_issue    = 0;
    int n_tick     = 0;
    int n_nop      = 0;
    int n_widths   = 1;
    int cycle_count = 0;

    logic [2:0] widths [7] = '{3'd4, 3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4};

    always #1 clk = ~clk;

    dual_issue_scoreboard dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (offer.func),
        .op_class     (offer.op_class),
        .src1_reg     (offer.src1_reg),
        .src1_valid   (offer.src1_valid),
        .src2_reg     (offer.src2_reg),
        .src2_valid   (offer.src2_valid),
        .src3_reg     (offer.src3_reg),
        .src3_valid   (offer.src3_valid),
        .dest_reg     (offer.dest_reg),
        .dest_valid   (offer.dest_valid),
        .latency      (offer.latency),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .can_issue    (can_issue),
        .free_slots   (free_slots)
    );

    issue_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (offer),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .can_issue    (can_issue),
        .free_slots   (free_slots),
        .mismatches   (mismatches),
        .pending      (pending),
        .granted      (granted)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    function automatic int sender_gap(input bit steady);
        if (steady || $urandom_range(0, 99) < 55)
            return 0;
        return pause_len();
    endfunction

    // Register indices cluster in a small set so sources often hit pending writes.
    function automatic logic [5:0] pick_reg();
        if ($urandom_range(0, 3) != 0)
            return 6'($urandom_range(0, 7));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic item_t random_instr(input func_t f);
        item_t it;
        int    r;
        it.func       = f;
        it.op_class   = op_class_t'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                                : $urandom_range(0, 5));
        it.src1_reg   = pick_reg();
        it.src1_valid = ($urandom_range(0, 9) < 7);
        it.src2_reg   = pick_reg();
        it.src2_valid = ($urandom_range(0, 9) < 7);
        it.src3_reg   = pick_reg();
        it.src3_valid = ($urandom_range(0, 9) < 4);
        it.dest_reg   = pick_reg();
        it.dest_valid = ($urandom_range(0, 9) < 8);
        r = $urandom_range(0, 99);
        if (r < 70)
            it.latency = 6'($urandom_range(0, 4));
        else if (r < 95)
            it.latency = 6'($urandom_range(5, 15));
        else
            it.latency = 6'($urandom_range(16, 63));
        return it;
    endfunction

    function automatic item_t mk(input func_t f, input op_class_t c,
                                 input logic [5:0] s1, input logic v1,
                                 input logic [5:0] s2, input logic v2,
                                 input logic [5:0] s3, input logic v3,
                                 input logic [5:0] d, input logic dv,
                                 input logic [5:0] lat);
        item_t it;
        it = '{f, c, s1, v1, s2, v2, s3, v3, d, dv, lat};
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send(input item_t it);
        offer      <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        case (it.func)
            FUNC_QUERY: n_query++;
            FUNC_ISSUE: n_issue++;
            FUNC_TICK:  n_tick++;
            default:    n_nop++;
        endcase
        @(negedge clk);
    endtask

    task automatic rest(input int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // The extra wait after the last result covers any stray output.
        repeat (6) @(negedge clk);
    endtask

    task automatic set_width(input logic [2:0] w);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        n_widths++;
    endtask

    task automatic play_sequence(input bit steady);
        item_t ins;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            // Ask first, then usually issue the same instruction.
            ins = random_instr(FUNC_QUERY);
            send(ins);
            rest(sender_gap(steady));
            if ($urandom_range(0, 4) != 0)
            begin
                ins.func = FUNC_ISSUE;
                send(ins);
                rest(sender_gap(steady));
            end
        end
        else if (r < 75)
        begin
            repeat ($urandom_range(1, 3))
            begin
                send(random_instr(FUNC_TICK));
                rest(sender_gap(steady));
            end
        end
        else if (r < 95)
        begin
            send(random_instr(func_t'($urandom_range(0, 2))));
            rest(sender_gap(steady));
        end
        else
        begin
            send(random_instr(FUNC_NOP));
            rest(sender_gap(steady));
        end
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off that
    // backs the block up into its input.
    initial
    begin
        int  stall_left;
        int  steady_left;
        bit  backlog_done;
        result_ready = 1'b0;
        stall_left   = 0;
        steady_left  = 0;
        backlog_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!backlog_done && items_sent >= BACKLOG_AT)
            begin
                result_ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge clk);
                backlog_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (steady_left > 0)
                    steady_left--;
                else if ($urandom_range(0, 99) < 25)
                    stall_left = pause_len();
                else if ($urandom_range(0, 99) < 3)
                    steady_left = $urandom_range(50, 150);
            end
        end
    end

    initial
    begin
        int start;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        item_valid = 1'b0;
        offer      = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset width of two slots.
        send(mk(FUNC_QUERY, CLS_OTHER, 0, 1, 0, 1, 0, 1, 0, 1, 0));
        send(mk(FUNC_ISSUE, CLS_FDIV, 63, 1, 63, 1, 63, 1, 63, 1, 63));
        send(mk(FUNC_QUERY, CLS_FDIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_FP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_MEM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_ISSUE, CLS_MEM, 1, 1, 2, 1, 3, 1, 0, 1, 0));
        // No slot left: the issue still lands and the count stays at zero.
        send(mk(FUNC_ISSUE, CLS_OTHER, 0, 0, 0, 0, 0, 0, 5, 1, 3));
        send(mk(FUNC_QUERY, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_TICK, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_OTHER, 63, 1, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_OTHER, 63, 0, 0, 0, 5, 1, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_OTHER, 0, 0, 5, 1, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_OTHER, 63, 0, 0, 0, 0, 0, 0, 0, 0));
        // Multiply checks the mul/div port but leaves it free.
        send(mk(FUNC_ISSUE, CLS_IMUL, 0, 0, 0, 0, 0, 0, 7, 1, 1));
        send(mk(FUNC_QUERY, CLS_IMUL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_ISSUE, CLS_IDIV, 0, 0, 0, 0, 0, 0, 8, 1, 1));
        send(mk(FUNC_TICK, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_QUERY, CLS_IDIV, 7, 1, 8, 1, 0, 0, 0, 0, 0));
        // Reserved classes behave as the plain class.
        send(mk(FUNC_QUERY, CLS_RSVD6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_ISSUE, CLS_RSVD7, 0, 0, 0, 0, 0, 0, 42, 1, 42));
        send(mk(FUNC_NOP, CLS_IDIV, 63, 1, 63, 1, 63, 1, 63, 1, 63));
        send(mk(FUNC_QUERY, CLS_FDIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FUNC_ISSUE, CLS_OTHER, 0, 0, 0, 0, 0, 0, 63, 0, 63));
        send(mk(FUNC_TICK, CLS_OTHER, 63, 1, 63, 1, 63, 1, 63, 1, 63));
        send(mk(FUNC_QUERY, CLS_OTHER, 42, 1, 0, 0, 0, 0, 0, 0, 0));

        // Random phases, one per issue-width setting.
        foreach (widths[p])
        begin
            bit steady;
            set_width(widths[p]);
            steady = ($urandom_range(0, 3) == 0);
            start  = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                play_sequence(steady);
        end

        drain();
        $display("Ran %0d transactions: %0d queries, %0d issues, %0d ticks, %0d unused codes.",
                 items_sent, n_query, n_issue, n_tick, n_nop);
        $display("%0d issue-width settings, %0d queries answered issuable, one long result stall.",
                 n_widths, granted);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
design/dis_pkg.sv
design/dis_reg_timers.sv
design/dual_issue_scoreboard.sv
sim/issue_checker.sv
sim/testbench.sv
